// File: hw/rtl/timebase_period_fixed_point_macros.svh
// Assertion helpers used by tpfp_cell.
`ifndef TIMEBASE_PERIOD_FIXED_POINT_MACROS_SVH
`define TIMEBASE_PERIOD_FIXED_POINT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked outside reset.
`define TPFP_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tpfp assertion failed");

// Property checked at every edge, reset included.
`define TPFP_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("tpfp reset assertion failed");

`else

`define TPFP_ASSERT(label, prop)
`define TPFP_ASSERT_RST(label, prop)

`endif

`endif

// File: hw/rtl/tpfp_pkg.sv
package tpfp_pkg;

    localparam int WHOLE_BITS = 8;
    localparam int DENOM_W    = 13;
    localparam int NUMER_W    = 12;

    localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;
    localparam logic [19:0] HZ_PER_MHZ    = 20'd1000000;
    localparam logic [31:0] TIMEBASE_MAX  = 32'h7fffffff;
    localparam logic [NUMER_W-1:0] RATIO_NUM = 12'd4000;

    // Largest timebase whose whole quotient still exceeds 255.
    localparam logic [31:0] TB_WHOLE_LIMIT = 32'(NS_PER_SECOND / (2 ** WHOLE_BITS));

    // Partial remainder ahead of the first quotient bit.
    localparam logic [30:0] REM_INIT = 31'(NS_PER_SECOND >> WHOLE_BITS);

    typedef struct packed {
        logic        ok;
        logic [30:0] tb_hz;
        logic [30:0] rem;
        logic [19:0] bus_rem;
        logic [DENOM_W-1:0] bus_lo;
    } tpfp_stage_t;

    // Dividend bit brought down at a given quotient step.
    function automatic logic dividend_bit(input int idx);
        logic b;
        b = 1'b0;
        if (idx < WHOLE_BITS) begin
            b = NS_PER_SECOND[5'(WHOLE_BITS-1-idx)];
        end
        return b;
    endfunction

endpackage

// File: hw/rtl/timebase_period_fixed_point.sv
// Timebase period converter. Each request carries a timebase frequency and a
// bus clock frequency in hertz; each gives one result: an ok flag, the ratio
// 4000 over the bus clock in whole megahertz, and 1e9 / timebase as unsigned
// fixed point with FRACTION_BITS fraction bits (8 integer bits, truncated).
// A request is rejected, with all other fields zero, when the bus clock is
// below 1 MHz, the timebase is 0 or above 0x7fffffff, or the integer part
// would exceed 255. The quotient comes from a row of 8 + FRACTION_BITS
// restoring-division cells, one quotient bit per cell; the first 13 cells
// also divide the bus clock by one million. A new request is taken every
// cycle unless m_ready stalls the row; each result passes every cell's
// register in turn. Reset is synchronous and active low.
module timebase_period_fixed_point import tpfp_pkg::*; #(
    parameter int FRACTION_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_timebase_hz,
    input  logic [31:0]        s_bus_clock_hz,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output logic [NUMER_W-1:0] m_ratio_numerator,
    output logic [DENOM_W-1:0] m_ratio_denominator,
    output logic [31:0]        m_period_fixed
);

    localparam int QUOT_W = WHOLE_BITS + FRACTION_BITS;
    localparam int NCELL  = QUOT_W;

    logic              stage_valid [0:NCELL];
    logic              stage_ready [0:NCELL];
    tpfp_stage_t       stage_data  [0:NCELL];
    logic [QUOT_W-1:0] stage_quot  [0:NCELL];
    tpfp_stage_t       last;

    // Screen the request on entry; the verdict rides along the row.
    always_comb begin
        stage_data[0].ok      = (s_bus_clock_hz >= 32'(HZ_PER_MHZ))
                                && (s_timebase_hz > TB_WHOLE_LIMIT)
                                && (s_timebase_hz <= TIMEBASE_MAX);
        stage_data[0].tb_hz   = s_timebase_hz[30:0];
        stage_data[0].rem     = REM_INIT;
        stage_data[0].bus_rem = 20'(s_bus_clock_hz[31:DENOM_W]);
        stage_data[0].bus_lo  = s_bus_clock_hz[DENOM_W-1:0];
    end

    assign stage_valid[0] = s_valid;
    assign stage_quot[0]  = '0;
    assign s_ready        = stage_ready[0];

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        tpfp_cell #(
            .CELL_IDX (i),
            .QUOT_W   (QUOT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (stage_valid[i]),
            .up_ready (stage_ready[i]),
            .up_data  (stage_data[i]),
            .up_quot  (stage_quot[i]),
            .dn_valid (stage_valid[i+1]),
            .dn_ready (stage_ready[i+1]),
            .dn_data  (stage_data[i+1]),
            .dn_quot  (stage_quot[i+1])
        );
    end

    assign last               = stage_data[NCELL];
    assign stage_ready[NCELL] = m_ready;
    assign m_valid            = stage_valid[NCELL];

    // Zero every field of a rejected request.
    assign m_ok                = last.ok;
    assign m_ratio_numerator   = last.ok ? RATIO_NUM : '0;
    assign m_ratio_denominator = last.ok ? last.bus_lo : '0;
    assign m_period_fixed      = last.ok ? 32'(stage_quot[NCELL]) : '0;

endmodule

// File: hw/rtl/tpfp_cell.sv
`include "timebase_period_fixed_point_macros.svh"

module tpfp_cell import tpfp_pkg::*; #(
    parameter int CELL_IDX = 0,
    parameter int QUOT_W   = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              up_valid,
    output logic              up_ready,
    input  tpfp_stage_t       up_data,
    input  logic [QUOT_W-1:0] up_quot,
    output logic              dn_valid,
    input  logic              dn_ready,
    output tpfp_stage_t       dn_data,
    output logic [QUOT_W-1:0] dn_quot
);

    localparam logic NUM_BIT = dividend_bit(CELL_IDX);

    logic              valid_reg;
    tpfp_stage_t       data_reg;
    tpfp_stage_t       data_next;
    logic [QUOT_W-1:0] quot_reg;
    logic [QUOT_W-1:0] quot_next;
    logic [31:0]       tb_trial;
    logic              tb_ge;
    logic [19:0]       bus_rem_next;
    logic [DENOM_W-1:0] bus_lo_next;

    assign up_ready = !valid_reg || dn_ready;

    // One restoring step on the period quotient.
    assign tb_trial = {up_data.rem, NUM_BIT};
    assign tb_ge    = tb_trial >= {1'b0, up_data.tb_hz};

    // One restoring step on the megahertz quotient while its bits last.
    if (CELL_IDX < DENOM_W) begin : g_bus
        logic [20:0] bus_trial;
        logic        bus_ge;
        assign bus_trial    = {up_data.bus_rem, up_data.bus_lo[DENOM_W-1]};
        assign bus_ge       = bus_trial >= {1'b0, HZ_PER_MHZ};
        assign bus_rem_next = bus_ge ? 20'(bus_trial - {1'b0, HZ_PER_MHZ})
                                     : bus_trial[19:0];
        assign bus_lo_next  = {up_data.bus_lo[DENOM_W-2:0], bus_ge};
    end else begin : g_bus_done
        assign bus_rem_next = up_data.bus_rem;
        assign bus_lo_next  = up_data.bus_lo;
    end

    always_comb begin
        data_next         = up_data;
        data_next.rem     = tb_ge ? 31'(tb_trial - {1'b0, up_data.tb_hz}) : tb_trial[30:0];
        data_next.bus_rem = bus_rem_next;
        data_next.bus_lo  = bus_lo_next;
        quot_next         = {up_quot[QUOT_W-2:0], tb_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
        if (up_valid && up_ready) begin
            data_reg <= data_next;
            quot_reg <= quot_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
    assign dn_quot  = quot_reg;

    `TPFP_ASSERT_RST(a_reset_clears, !aresetn |=> !valid_reg)
    `TPFP_ASSERT(a_take_fills, up_valid && up_ready |=> valid_reg)
    `TPFP_ASSERT(a_stall_holds, valid_reg && !dn_ready |=> valid_reg && $stable(quot_reg))
    `TPFP_ASSERT(a_rem_bounded, valid_reg && data_reg.ok |-> data_reg.rem < data_reg.tb_hz)
    `TPFP_ASSERT(a_bus_rem_bounded, valid_reg |-> data_reg.bus_rem < HZ_PER_MHZ)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tpfp_pkg::*;

    localparam int          FRAC_BITS   = 24;
    localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;
    localparam logic [31:0] BUS_MIN_HZ  = 32'd1000000;
    localparam logic [31:0] TB_HIGH_OK  = 32'h7fffffff;
    localparam logic [31:0] TB_LOW_OK   = 32'd3906251;  // smallest timebase with whole <= 255
    localparam logic [63:0] WHOLE_LIMIT = 64'd255;
    localparam logic [NUMER_W-1:0] NUMER_OK = 12'd4000;
    localparam int RANDOM_REQUESTS = 450;
    localparam int CALM_TAIL       = 50;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int DRAIN_CYCLES    = 64;

    typedef struct packed {
        logic               ok;
        logic [NUMER_W-1:0] numer;
        logic [DENOM_W-1:0] denom;
        logic [31:0]        period;
    } period_result_t;

    typedef struct {
        logic [31:0]    tb_hz;
        logic [31:0]    bus_hz;
        bit             typed;
        period_result_t want;
    } period_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [31:0]        s_timebase_hz;
    logic [31:0]        s_bus_clock_hz;
    logic               m_valid;
    logic               m_ready;
    logic               m_ok;
    logic [NUMER_W-1:0] m_ratio_numerator;
    logic [DENOM_W-1:0] m_ratio_denominator;
    logic [31:0]        m_period_fixed;

    period_result_t expected_periods[$];
    period_row_t    directed_rows[$];
    period_result_t row_want;
    bit             row_typed;
    bit             calm;
    int             requests_taken;
    int             errors;

    timebase_period_fixed_point u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_timebase_hz       (s_timebase_hz),
        .s_bus_clock_hz      (s_bus_clock_hz),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_ok                (m_ok),
        .m_ratio_numerator   (m_ratio_numerator),
        .m_ratio_denominator (m_ratio_denominator),
        .m_period_fixed      (m_period_fixed)
    );

    always #1 aclk = ~aclk;

    // 1e9 / timebase in 8.24 fixed point, fraction by restoring division
    function automatic period_result_t compute_period(logic [31:0] tb_hz, logic [31:0] bus_hz);
        period_result_t r;
        logic [63:0]    whole;
        logic [63:0]    rem;
        logic [63:0]    frac;
        int             k;
        r = '0;
        if (bus_hz < BUS_MIN_HZ || tb_hz == 32'd0 || tb_hz > TB_HIGH_OK) begin
            return r;
        end
        whole = NS_PER_SEC / {32'd0, tb_hz};
        if (whole > WHOLE_LIMIT) begin
            return r;
        end
        rem  = NS_PER_SEC % {32'd0, tb_hz};
        frac = 64'd0;
        for (k = 0; k < FRAC_BITS; k++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= {32'd0, tb_hz}) begin
                rem  = rem - {32'd0, tb_hz};
                frac = frac | 64'd1;
            end
        end
        r.ok     = 1'b1;
        r.numer  = NUMER_OK;
        r.denom  = DENOM_W'(bus_hz / BUS_MIN_HZ);
        r.period = 32'((whole << FRAC_BITS) | frac);
        return r;
    endfunction

    function automatic void add_row(logic [31:0] tb_hz, logic [31:0] bus_hz, bit typed,
                                    logic ok, logic [NUMER_W-1:0] numer,
                                    logic [DENOM_W-1:0] denom, logic [31:0] period);
        period_row_t row;
        row.tb_hz       = tb_hz;
        row.bus_hz      = bus_hz;
        row.typed       = typed;
        row.want.ok     = ok;
        row.want.numer  = numer;
        row.want.denom  = denom;
        row.want.period = period;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Mostly well-formed requests, the rest spread over every reject path.
    function automatic void random_request(output logic [31:0] tb_hz,
                                           output logic [31:0] bus_hz);
        int mode;
        mode   = $urandom_range(0, 9);
        bus_hz = $urandom_range(32'hffffffff, BUS_MIN_HZ);
        case (mode)
            0, 1: begin
                tb_hz = $urandom_range(TB_LOW_OK + 32'd20000000, TB_LOW_OK);
            end
            2, 3, 4, 5: begin
                tb_hz = $urandom_range(TB_HIGH_OK, TB_LOW_OK);
            end
            6: begin
                tb_hz  = $urandom;
                bus_hz = $urandom;
            end
            7: begin
                tb_hz = $urandom_range(TB_LOW_OK - 32'd1, 32'd0);
            end
            8: begin
                tb_hz  = $urandom_range(TB_HIGH_OK, TB_LOW_OK);
                bus_hz = $urandom_range(BUS_MIN_HZ - 32'd1, 32'd0);
            end
            default: begin
                tb_hz = $urandom_range(32'hffffffff, TB_HIGH_OK + 32'd1);
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (row_typed) begin
                    expected_periods.push_back(row_want);
                end else begin
                    expected_periods.push_back(compute_period(s_timebase_hz, s_bus_clock_hz));
                end
                requests_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_periods.size() == 0) begin
                    $display("%0t: result with no pending request, period %0h", $time,
                             m_period_fixed);
                    errors++;
                end else begin
                    period_result_t want;
                    want = expected_periods.pop_front();
                    check_field("ok", 32'(want.ok), 32'(m_ok));
                    check_field("ratio_numerator", 32'(want.numer), 32'(m_ratio_numerator));
                    check_field("ratio_denominator", 32'(want.denom),
                                32'(m_ratio_denominator));
                    check_field("period_fixed", want.period, m_period_fixed);
                end
            end
        end
    end

    // Receiver: random ready bursts, one long hold-off to back up the pipeline.
    initial begin
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && requests_taken >= HOLD_OFF_AFTER) begin
                held    = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(19, 1) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(40, 1) - 1) @(negedge aclk);
            end
        end
    end

    // Sender: directed table first, then random requests.
    initial begin
        logic [31:0] tb_hz;
        logic [31:0] bus_hz;
        int          total;
        int          i;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_timebase_hz  = '0;
        s_bus_clock_hz = '0;
        row_typed      = 1'b0;
        row_want       = '0;
        calm           = 1'b0;
        requests_taken = 0;
        errors         = 0;

        // rejects
        add_row(32'd0,          32'd100000000, 1'b1, 1'b0, '0, '0, '0);
        add_row(32'hffffffff,   32'd100000000, 1'b1, 1'b0, '0, '0, '0);
        add_row(32'h80000000,   32'hffffffff,  1'b1, 1'b0, '0, '0, '0);
        add_row(32'd1,          32'hffffffff,  1'b1, 1'b0, '0, '0, '0);
        add_row(32'd3906250,    32'd100000000, 1'b1, 1'b0, '0, '0, '0);
        add_row(32'd1000000000, 32'd999999,    1'b1, 1'b0, '0, '0, '0);
        add_row(32'd1000000000, 32'd0,         1'b1, 1'b0, '0, '0, '0);
        add_row(32'd0,          32'd0,         1'b1, 1'b0, '0, '0, '0);
        add_row(32'hffffffff,   32'd0,         1'b1, 1'b0, '0, '0, '0);
        // exact quotients
        add_row(32'd1000000000, 32'd1000000,   1'b1, 1'b1, NUMER_OK, 13'd1, 32'h01000000);
        add_row(32'd500000000,  32'hffffffff,  1'b1, 1'b1, NUMER_OK, 13'd4294, 32'h02000000);
        add_row(32'd4000000,    32'd33000000,  1'b1, 1'b1, NUMER_OK, 13'd33, 32'hfa000000);
        add_row(32'd2000000000, 32'd1999999,   1'b1, 1'b1, NUMER_OK, 13'd1, 32'h00800000);
        // truncated fractions, edges of the accepted range and one more reject
        add_row(32'd3906251,    32'd100000000, 1'b0, 1'b0, '0, '0, '0);
        add_row(32'h7fffffff,   32'hffffffff,  1'b0, 1'b0, '0, '0, '0);
        add_row(32'd33333333,   32'd66666666,  1'b0, 1'b0, '0, '0, '0);
        add_row(32'd25000000,   32'd133000000, 1'b0, 1'b0, '0, '0, '0);
        add_row(32'd18432000,   32'd1000001,   1'b0, 1'b0, '0, '0, '0);
        add_row(32'd3,          32'd1000000,   1'b0, 1'b0, '0, '0, '0);
        add_row(32'h55555555,   32'haaaaaaaa,  1'b0, 1'b0, '0, '0, '0);
        add_row(32'h2aaaaaaa,   32'h55555555,  1'b0, 1'b0, '0, '0, '0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        total = directed_rows.size() + RANDOM_REQUESTS;
        for (i = 0; i < total; i++) begin
            @(negedge aclk);
            if (total - i <= CALM_TAIL) begin
                calm = 1'b1;
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(19, 1)) @(negedge aclk);
            end
            if (i < directed_rows.size()) begin
                tb_hz     = directed_rows[i].tb_hz;
                bus_hz    = directed_rows[i].bus_hz;
                row_typed <= directed_rows[i].typed;
                row_want  <= directed_rows[i].want;
            end else begin
                random_request(tb_hz, bus_hz);
                row_typed <= 1'b0;
            end
            s_valid        <= 1'b1;
            s_timebase_hz  <= tb_hz;
            s_bus_clock_hz <= bus_hz;
            // hold the request until it is taken
            do @(posedge aclk); while (!s_ready);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (expected_periods.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule
